// ===== src/framed_message_byte_parser_unit_assert.svh =====
// assertion macros shared by the parser modules
`ifndef FRAMED_MESSAGE_BYTE_PARSER_UNIT_ASSERT_SVH
`define FRAMED_MESSAGE_BYTE_PARSER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FMBP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define FMBP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/fmbp_pkg.sv =====
// shared constants, types and codes of the framed message byte parser
package fmbp_pkg;

    localparam int MAX_PAYLOAD = 31;
    localparam int STORE_AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 3;

    // parse state of the frame
    typedef enum logic [2:0] {
        FS_IDLE  = 3'd0,
        FS_START = 3'd1,
        FS_LEN   = 3'd2,
        FS_ID    = 3'd3,
        FS_SEQ   = 3'd4,
        FS_PAY   = 3'd5,
        FS_DONE  = 3'd6,
        FS_ERR   = 3'd7
    } frame_state_t;

    // status code carried with each result
    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_COLLECT  = 2'd1,
        ST_RECEIVED = 2'd2,
        ST_ERROR    = 2'd3
    } msg_status_t;

    // sequencing controller states
    typedef enum logic [1:0] {
        CS_INPUT = 2'd0,
        CS_READ  = 2'd1,
        CS_EMIT  = 2'd2
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic step;         // input item accepted this cycle
        logic rd_issue;     // read store at stream counter
        logic load_stream;  // load a streamed payload result
    } fmbp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic stream_start; // accepted byte completes a non-empty message
        logic out_free;     // output register can take a result this cycle
        logic last_byte;    // stream counter is at the final payload byte
    } fmbp_sts_t;

endpackage

// ===== src/fmbp_ctrl.sv =====
// controller for input acceptance and payload streaming
`include "framed_message_byte_parser_unit_assert.svh"

module fmbp_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  fmbp_pkg::fmbp_sts_t sts,
    output fmbp_pkg::fmbp_cmd_t cmd
);
    import fmbp_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_INPUT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        s_tready         = 1'b0;
        cmd.step         = 1'b0;
        cmd.rd_issue     = 1'b0;
        cmd.load_stream  = 1'b0;
        case (state_reg)
            CS_INPUT: begin
                s_tready = sts.out_free;
                if (s_tvalid && sts.out_free) begin
                    cmd.step = 1'b1;
                    if (sts.stream_start) begin
                        state_next = CS_READ;
                    end
                end
            end
            CS_READ: begin
                cmd.rd_issue = 1'b1;
                state_next   = CS_EMIT;
            end
            CS_EMIT: begin
                if (sts.out_free) begin
                    cmd.load_stream = 1'b1;
                    state_next      = sts.last_byte ? CS_INPUT : CS_READ;
                end
            end
            default: begin
                state_next = CS_INPUT;
            end
        endcase
    end

    `FMBP_ASSERT_NXT(a_stream_begins, cmd.step && sts.stream_start,
        state_reg == CS_READ, "completed message did not start streaming")
    `FMBP_ASSERT_NOW(a_no_input_while_streaming, state_reg != CS_INPUT,
        !s_tready, "input taken while payload streams")
    `FMBP_ASSERT_NXT(a_stream_ends, cmd.load_stream && sts.last_byte,
        state_reg == CS_INPUT, "stream did not end after its final byte")

endmodule

// ===== src/fmbp_dp.sv =====
// frame parsing datapath, payload store and output register
`include "framed_message_byte_parser_unit_assert.svh"

module fmbp_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [fmbp_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [fmbp_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic [fmbp_pkg::OUT_TUSER_W-1:0]     m_tuser,
    output logic                                 m_tlast,
    input  fmbp_pkg::fmbp_cmd_t                  cmd,
    output fmbp_pkg::fmbp_sts_t                  sts
);
    import fmbp_pkg::*;

    // frame registers
    frame_state_t fstate_reg, fstate_next;
    logic [5:0]   seq_reg, seq_next;
    logic [5:0]   slot_reg, slot_next;
    logic [7:0]   len_reg, len_next;
    logic [7:0]   id_reg, id_next;
    logic [7:0]   ck_reg, ck_next;

    // payload store and stream counter
    logic [7:0]   store_mem [MAX_PAYLOAD];
    logic [7:0]   rd_data_reg;
    logic [5:0]   cnt_reg;

    // output register
    logic         out_valid_reg;
    msg_status_t  out_status_reg;
    logic [7:0]   out_id_reg;
    logic [7:0]   out_len_reg;
    logic         out_pvalid_reg;
    logic [5:0]   out_index_reg;
    logic [7:0]   out_byte_reg;
    logic         out_last_reg;

    logic [7:0]   in_byte;
    logic [2:0]   in_pos;
    logic         start_c;
    logic         done_c;
    logic         store_we;
    logic         add_en;
    logic [8:0]   sum9;
    logic [7:0]   ck_sum;
    msg_status_t  single_status;
    logic         load_single;

    assign in_byte = s_tdata[7:0];
    assign in_pos  = s_tdata[10:8];
    assign start_c = (in_pos == 3'd0) && (in_byte == 8'd0);

    // end-around-carry add of the incoming byte
    assign sum9   = {1'b0, ck_reg} + {1'b0, in_byte};
    assign ck_sum = sum9[7:0] + {7'd0, sum9[8]};

    always_comb begin
        fstate_next = fstate_reg;
        seq_next    = seq_reg;
        slot_next   = slot_reg;
        len_next    = len_reg;
        id_next     = id_reg;
        ck_next     = ck_reg;
        done_c      = 1'b0;
        store_we    = 1'b0;
        add_en      = 1'b0;
        if (start_c) begin
            fstate_next = FS_START;
            seq_next    = 6'd0;
            slot_next   = 6'd0;
            len_next    = 8'd0;
            id_next     = 8'd0;
            ck_next     = 8'd0;
        end else begin
            case (fstate_reg)
                FS_START: begin
                    len_next    = in_byte;
                    add_en      = 1'b1;
                    fstate_next = (in_byte > 8'(MAX_PAYLOAD)) ? FS_ERR : FS_LEN;
                end
                FS_LEN: begin
                    id_next     = in_byte;
                    add_en      = 1'b1;
                    fstate_next = FS_ID;
                end
                FS_ID: begin
                    store_we    = 1'b1;
                    fstate_next = FS_PAY;
                end
                FS_SEQ, FS_PAY: begin
                    if ((fstate_reg == FS_PAY) && (in_pos == 3'd0)) begin
                        // sequence byte: low bits must be one past the last
                        add_en = 1'b1;
                        if ({1'b0, in_byte[5:0]} != ({1'b0, seq_reg} + 7'd1)) begin
                            fstate_next = FS_ERR;
                        end else begin
                            seq_next    = in_byte[5:0];
                            fstate_next = FS_SEQ;
                        end
                    end else if ({2'd0, slot_reg} < len_reg) begin
                        store_we    = 1'b1;
                        fstate_next = FS_PAY;
                    end else if (ck_reg == in_byte) begin
                        fstate_next = FS_DONE;
                        done_c      = 1'b1;
                    end else begin
                        fstate_next = FS_ERR;
                    end
                end
                FS_DONE: begin
                    fstate_next = FS_DONE;
                end
                default: begin
                    fstate_next = FS_ERR;
                end
            endcase
            if (store_we) begin
                slot_next = slot_reg + 6'd1;
                add_en    = 1'b1;
            end
            if (add_en) begin
                ck_next = ck_sum;
            end
        end
    end

    always_comb begin
        case (fstate_next)
            FS_IDLE: single_status = ST_IDLE;
            FS_DONE: single_status = ST_RECEIVED;
            FS_ERR:  single_status = ST_ERROR;
            default: single_status = ST_COLLECT;
        endcase
    end

    assign sts.stream_start = done_c && (len_reg != 8'd0);
    assign sts.out_free     = !out_valid_reg || m_tready;
    assign sts.last_byte    = (({2'd0, cnt_reg} + 8'd1) == len_reg);
    assign load_single      = cmd.step && !sts.stream_start;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fstate_reg <= FS_IDLE;
            seq_reg    <= 6'd0;
            slot_reg   <= 6'd0;
            len_reg    <= 8'd0;
            id_reg     <= 8'd0;
            ck_reg     <= 8'd0;
        end else if (cmd.step) begin
            fstate_reg <= fstate_next;
            seq_reg    <= seq_next;
            slot_reg   <= slot_next;
            len_reg    <= len_next;
            id_reg     <= id_next;
            ck_reg     <= ck_next;
        end
    end

    // store written on accepted payload bytes, read one slot per stream step
    always_ff @(posedge aclk) begin
        if (cmd.step && store_we && (slot_reg < 6'(MAX_PAYLOAD))) begin
            store_mem[slot_reg[STORE_AW-1:0]] <= in_byte;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= store_mem[cnt_reg[STORE_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 6'd0;
        end else if (cmd.step) begin
            cnt_reg <= 6'd0;
        end else if (cmd.load_stream) begin
            cnt_reg <= cnt_reg + 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_single || cmd.load_stream) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_single) begin
            out_status_reg <= single_status;
            out_id_reg     <= (single_status == ST_RECEIVED) ? id_next : 8'd0;
            out_len_reg    <= (single_status == ST_RECEIVED) ? len_next : 8'd0;
            out_pvalid_reg <= 1'b0;
            out_index_reg  <= 6'd0;
            out_byte_reg   <= 8'd0;
            out_last_reg   <= 1'b1;
        end else if (cmd.load_stream) begin
            out_status_reg <= ST_RECEIVED;
            out_id_reg     <= id_reg;
            out_len_reg    <= len_reg;
            out_pvalid_reg <= 1'b1;
            out_index_reg  <= cnt_reg;
            out_byte_reg   <= rd_data_reg;
            out_last_reg   <= sts.last_byte;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_pvalid_reg, out_status_reg};
    assign m_tdata  = {2'b00, out_byte_reg, out_index_reg, out_len_reg, out_id_reg};

    `FMBP_ASSERT_NOW(a_load_only_when_free, load_single || cmd.load_stream,
        sts.out_free, "result loaded over one not yet taken")
    `FMBP_ASSERT_NOW(a_payload_is_received, out_valid_reg && out_pvalid_reg,
        out_status_reg == ST_RECEIVED, "payload result without received status")
    `FMBP_ASSERT_NOW(a_length_in_store,
        fstate_reg == FS_PAY || fstate_reg == FS_SEQ || fstate_reg == FS_DONE,
        len_reg <= 8'(MAX_PAYLOAD), "frame length beyond payload store")

endmodule

// ===== src/framed_message_byte_parser_unit.sv =====
// top level of the framed message byte parser
//
//  channel | ports                      | contents (lowest bit up)
//  --------+----------------------------+---------------------------------------------
//  input   | s_tvalid s_tready s_tdata  | data_byte[7:0], byte_position[10:8], zeros
//  result  | m_tvalid m_tready m_tdata  | message_id, message_length, payload_index,
//          | m_tuser m_tlast            |   payload_byte, zeros; tuser status, valid
//
// an input item whose result is single has that result loaded when it is accepted;
// its result sits in the output register while the next item is already accepted
// an item that completes a non-empty message streams its payload from the store
// byte by byte (store read, then output load, held while the output register is full)
// the controller alternates store read and output load
// aresetn is synchronous and active low; it returns the parser to idle
// no item is taken while payload streams or while the output register is full
// and not being drained
module framed_message_byte_parser_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // data_byte[7:0], byte_position[10:8], zero fill
    input  logic [fmbp_pkg::IN_TDATA_W-1:0]       s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // message_id[7:0], message_length[15:8], payload_index[21:16],
    // payload_byte[29:22], zero fill
    output logic [fmbp_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // status[1:0], payload_valid[2]
    output logic [fmbp_pkg::OUT_TUSER_W-1:0]      m_tuser,
    output logic                                  m_tlast
);
    import fmbp_pkg::*;

    // command and status between controller and datapath
    fmbp_cmd_t cmd;
    fmbp_sts_t sts;

    // sequencing: acceptance, store reads, result loads
    fmbp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // frame parse, checksum, payload store and output register
    fmbp_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
